/* rtl/kbt_pkg.sv */
`timescale 1ns / 1ps

package kbt_pkg;

  localparam int REPORT_SLOTS = 6;
  localparam int CNT_W        = 3;

  localparam logic [7:0] NO_KEY     = 8'hFF;
  localparam logic [4:0] MOD_PREFIX = 5'b11100;  // 0xE0..0xE7

  typedef struct packed {
    logic       command;
    logic [7:0] usage_code;
    logic       released;
    logic       send_report;
  } kbt_in_t;

  typedef struct packed {
    logic [7:0]       modifier_byte;
    logic [7:0]       slot_zero;
    logic [7:0]       slot_one;
    logic [7:0]       slot_two;
    logic [7:0]       slot_three;
    logic [7:0]       slot_four;
    logic [7:0]       slot_five;
    logic [CNT_W-1:0] keys_held;
    logic             any_held;
  } kbt_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic search;
    logic update;
    logic emit;
  } kbt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_hold;
  } kbt_sts_t;

endpackage

/* rtl/kbt_ctrl.sv */
`timescale 1ns / 1ps

module kbt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  kbt_pkg::kbt_sts_t sts,
  output kbt_pkg::kbt_cmd_t cmd
);
  import kbt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_SEARCH;
      S_SEARCH: state_next = S_UPDATE;
      S_UPDATE: state_next = S_EMIT;
      S_EMIT:   if (!sts.out_hold) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

  always_comb begin
    cmd.capture = (state == S_IDLE) && accept;
    cmd.search  = (state == S_SEARCH);
    cmd.update  = (state == S_UPDATE);
    // emit only once the output register can take the report
    cmd.emit    = (state == S_EMIT) && !sts.out_hold;
  end

endmodule

/* rtl/kbt_datapath.sv */
`timescale 1ns / 1ps

module kbt_datapath #(
  parameter int KEY_SLOTS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  kbt_pkg::kbt_in_t  in_data,
  input  kbt_pkg::kbt_cmd_t cmd,
  output kbt_pkg::kbt_sts_t sts,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kbt_pkg::kbt_out_t out_data
);
  import kbt_pkg::*;

  kbt_in_t          item;
  logic [7:0]       slots      [KEY_SLOTS];
  logic [7:0]       slots_next [KEY_SLOTS];
  logic [7:0]       slot_pad   [REPORT_SLOTS+1];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [7:0]       mods;
  logic [7:0]       mods_next;
  logic             report_enable;

  // search results, registered between SEARCH and UPDATE
  logic                 dup;
  logic [KEY_SLOTS-1:0] shift_mask;
  logic                 dup_c;
  logic [KEY_SLOTS-1:0] shift_mask_c;

  logic is_mod;

  assign cfg_ready    = 1'b1;
  assign sts.out_hold = out_valid && out_stall;
  assign is_mod       = (item.usage_code[7:3] == MOD_PREFIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      report_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      report_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
  end

  // zero-padded view: covers shift-in from above and unused report slots
  always_comb begin
    for (int i = 0; i <= REPORT_SLOTS; i++) begin
      slot_pad[i] = '0;
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      slot_pad[i] = slots[i];
    end
  end

  // press checks every slot; release only the occupied ones, first hit
  always_comb begin
    logic seen;
    seen  = 1'b0;
    dup_c = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      dup_c           = dup_c | (slots[i] == item.usage_code);
      seen            = seen | ((slots[i] == item.usage_code) && (CNT_W'(i) < count));
      shift_mask_c[i] = seen;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      dup        <= dup_c;
      shift_mask <= shift_mask_c;
    end
  end

  always_comb begin
    slots_next = slots;
    count_next = count;
    mods_next  = mods;
    if (item.command) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots_next[i] = '0;
      end
      count_next = '0;
    end else if (item.usage_code != NO_KEY) begin
      if (is_mod) begin
        mods_next[item.usage_code[2:0]] = !item.released;
      end else if (item.released) begin
        if (shift_mask[KEY_SLOTS-1]) begin
          // slots past count are always zero, so the top fills with zero
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (shift_mask[i]) slots_next[i] = slot_pad[i+1];
          end
          count_next = count - CNT_W'(1);
        end
      end else if (!dup && (count < CNT_W'(KEY_SLOTS))) begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (CNT_W'(i) == count) slots_next[i] = item.usage_code;
        end
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots[i] <= '0;
      end
      count <= '0;
      mods  <= '0;
    end else if (cmd.update) begin
      slots <= slots_next;
      count <= count_next;
      mods  <= mods_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && item.send_report && report_enable) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && item.send_report && report_enable) begin
      out_data.modifier_byte <= mods;
      out_data.slot_zero     <= slot_pad[0];
      out_data.slot_one      <= slot_pad[1];
      out_data.slot_two      <= slot_pad[2];
      out_data.slot_three    <= slot_pad[3];
      out_data.slot_four     <= slot_pad[4];
      out_data.slot_five     <= slot_pad[5];
      out_data.keys_held     <= count;
      out_data.any_held      <= (count != '0) || (mods != '0);
    end
  end

endmodule

/* rtl/keyboard_report_key_tracker.sv */
`timescale 1ns / 1ps
// After the edge that accepts the input request, the SEARCH, UPDATE and EMIT
//   states do the slot search, list update and report load in turn.
// One item at a time: a new request is not taken until EMIT is done,
//   so it also waits while a finished report is stalled.
// Reset (rst, synchronous, active high) empties the slots, clears modifiers,
//   disables reports and drops any pending report.
module keyboard_report_key_tracker #(
  parameter int KEY_SLOTS = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  kbt_pkg::kbt_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output kbt_pkg::kbt_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);
  import kbt_pkg::*;

  kbt_cmd_t cmd;
  kbt_sts_t sts;

  kbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kbt_datapath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/kbt_checker.sv */
`timescale 1ns / 1ps

module kbt_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input kbt_pkg::kbt_out_t out_data
);
  import kbt_pkg::*;

  // a pending report waits in place
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled report changed");

  // one request in flight: the block stalls right after taking it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after request");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.keys_held <= CNT_W'(REPORT_SLOTS))
    else $error("keys_held out of range");

  a_any_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.any_held ==
      ((out_data.keys_held != '0) || (out_data.modifier_byte != '0)))
    else $error("any_held inconsistent");

endmodule

bind keyboard_report_key_tracker kbt_checker u_kbt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
